@@ design/tlew_pkg.sv @@
`default_nettype none

package tlew_pkg;

  // Token kinds on the result channel
  typedef enum logic [2:0] {
    KIND_ECHO    = 3'd0,
    KIND_NEWLINE = 3'd1,
    KIND_BELL    = 3'd2,
    KIND_ERASE   = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  // Classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_ERASE   = 3'd0,
    OP_KILL    = 3'd1,
    OP_WORD    = 3'd2,
    OP_EOF     = 3'd3,
    OP_NEWLINE = 3'd4,
    OP_PRINT   = 3'd5,
    OP_BELL    = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } item_t;

  localparam int CNT_W = 6;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       echo;
    logic [CNT_W-1:0] count;
    logic             last;
  } tok_t;

  localparam logic [7:0] CTRL_D   = 8'd4;
  localparam logic [7:0] CTRL_W   = 8'd23;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd127;

  // Configuration space
  localparam int          CFG_AW        = 3;
  localparam logic        REG_ERASE     = 1'b0;
  localparam logic        REG_KILL      = 1'b1;
  localparam logic [7:0]  ERASE_RST     = 8'd127;
  localparam logic [7:0]  KILL_RST      = 8'd21;

endpackage

`default_nettype wire

@@ design/terminal_line_editor_word_wrap.sv @@
// Flow: a single-token transaction (echo, newline, bell, erase, kill) passes through the
//   op queue register and then the result register before it shows on the result side.
// Throughput: single-token items 1 per cycle while the result register is popped; Ctrl-W and a
//   wrap are set by the one-read-per-cycle walk of the line store RAM.
// Reset (rst_n, synchronous, low): cursor, session flag, queues and output cleared,
//   erase_char=127, kill_char=21; line store is not cleared and needs no clearing pass.
`default_nettype none

module terminal_line_editor_word_wrap #(
  parameter int LINE_WIDTH = 40
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // APB-style configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tlew_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // typed bytes in
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  in_byte,
  // echo tokens out
  output logic                             empty,
  input  wire logic                        pop,
  output logic      [2:0]                  out_token_kind,
  output logic      [7:0]                  out_echo_value,
  output logic      [5:0]                  out_erase_count,
  output logic                             out_last_of_run
);

  // front -> queue
  logic             fq_push;
  tlew_pkg::item_t  fq_item;
  logic             fq_full;
  // queue -> back
  logic             qb_valid;
  tlew_pkg::item_t  qb_item;
  logic             qb_pop;
  // result register
  logic             res_valid;
  tlew_pkg::tok_t   res_tok;

  // Front: config registers and byte classification; one transaction per cycle while the op queue is not full.
  tlew_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .q_push_o (fq_push),
    .q_item_o (fq_item),
    .q_full_i (fq_full)
  );

  // Two-entry op queue lets typing continue while the back end walks the line.
  tlew_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (fq_full),
    .valid_o (qb_valid),
    .item_o  (qb_item),
    .pop_i   (qb_pop)
  );

  // Back: line store, cursor, session flag, token sequencing and result register.
  tlew_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (qb_valid),
    .q_item_i    (qb_item),
    .q_pop_o     (qb_pop),
    .out_valid_o (res_valid),
    .out_tok_o   (res_tok),
    .pop_i       (pop)
  );

  assign empty           = !res_valid;
  assign out_token_kind  = res_tok.kind;
  assign out_echo_value  = res_tok.echo;
  assign out_erase_count = res_tok.count;
  assign out_last_of_run = res_tok.last;

endmodule

`default_nettype wire

@@ design/tlew_ram.sv @@
`default_nettype none

module tlew_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/tlew_front.sv @@
`default_nettype none

module tlew_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // config
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tlew_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    in_byte,
  // to op queue
  output logic                               q_push_o,
  output tlew_pkg::item_t                    q_item_o,
  input  wire logic                          q_full_i
);

  logic [7:0] erase_char_r;
  logic [7:0] kill_char_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_char_r <= tlew_pkg::ERASE_RST;
      kill_char_r  <= tlew_pkg::KILL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tlew_pkg::REG_ERASE: erase_char_r <= pwdata[7:0];
        tlew_pkg::REG_KILL:  kill_char_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tlew_pkg::REG_ERASE: prdata = {24'd0, erase_char_r};
      tlew_pkg::REG_KILL:  prdata = {24'd0, kill_char_r};
      default:             prdata = 32'd0;
    endcase
  end

  // classification, in priority order
  always_comb begin
    q_item_o.ch = in_byte;
    if (in_byte == erase_char_r) begin
      q_item_o.op = tlew_pkg::OP_ERASE;
    end else if (in_byte == kill_char_r) begin
      q_item_o.op = tlew_pkg::OP_KILL;
    end else if (in_byte == tlew_pkg::CTRL_W) begin
      q_item_o.op = tlew_pkg::OP_WORD;
    end else if (in_byte == tlew_pkg::CTRL_D) begin
      q_item_o.op = tlew_pkg::OP_EOF;
    end else if (in_byte == tlew_pkg::CH_NL) begin
      q_item_o.op = tlew_pkg::OP_NEWLINE;
    end else if (in_byte >= tlew_pkg::PRINT_LO && in_byte <= tlew_pkg::PRINT_HI) begin
      q_item_o.op = tlew_pkg::OP_PRINT;
    end else begin
      q_item_o.op = tlew_pkg::OP_BELL;
    end
  end

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

endmodule

`default_nettype wire

@@ design/tlew_opq.sv @@
`default_nettype none

module tlew_opq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_i,
  input  wire tlew_pkg::item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output tlew_pkg::item_t      item_o,
  input  wire logic            pop_i
);

  localparam int DEPTH = 2;

  tlew_pkg::item_t ent_r [DEPTH];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full_o  = (cnt_r == 2'(DEPTH));
  assign valid_o = (cnt_r != 2'd0);
  assign item_o  = ent_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ design/tlew_back.sv @@
`default_nettype none

module tlew_back #(
  parameter int LINE_WIDTH = 40
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid_i,
  input  wire tlew_pkg::item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  output tlew_pkg::tok_t       out_tok_o,
  input  wire logic            pop_i
);

  localparam int CW = $clog2(LINE_WIDTH + 1);
  localparam int AW = $clog2(LINE_WIDTH);
  localparam logic [CW-1:0] LW     = CW'(LINE_WIDTH);
  localparam logic [CW-1:0] ZERO   = CW'(0);
  localparam logic [CW-1:0] ONE    = CW'(1);
  localparam logic [CW-1:0] TWO    = CW'(2);
  localparam logic [AW-1:0] LAST_A = AW'(LINE_WIDTH - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CW     = 8'b0000_0010,
    S_CWEND  = 8'b0000_0100,
    S_WSCAN  = 8'b0000_1000,
    S_WERASE = 8'b0001_0000,
    S_WNL    = 8'b0010_0000,
    S_MOVE   = 8'b0100_0000,
    S_WECHO  = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;   // word-erase point, wrap start, move source
  logic            word_r, word_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic            sess_r, sess_nxt;
  logic            ov_r, ov_nxt;
  tlew_pkg::tok_t  tok_r, tok_nxt;

  logic            emit, emit_ok;
  tlew_pkg::tok_t  emit_tok;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;
  logic            rd_space;
  logic [CW-1:0]   pos_m1, pos_p1, scan_m1, scan_m2, scan_p1;
  logic [CW-1:0]   cw_cnt, wrap_cnt;

  tlew_ram #(
    .WIDTH (8),
    .DEPTH (LINE_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign emit_ok  = !ov_r || pop_i;
  assign rd_space = (rdata == tlew_pkg::CH_SPACE);
  assign pos_m1   = pos_r - ONE;
  assign pos_p1   = pos_r + ONE;
  assign scan_m1  = scan_r - ONE;
  assign scan_m2  = scan_r - TWO;
  assign scan_p1  = scan_r + ONE;
  assign cw_cnt   = pos_r - scan_r;
  assign wrap_cnt = LW - scan_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    scan_nxt  = scan_r;
    word_nxt  = word_r;
    ch_nxt    = ch_r;
    sess_nxt  = sess_r;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_tok  = '{kind: tlew_pkg::KIND_ECHO, echo: 8'd0, count: '0, last: 1'b1};
    we        = 1'b0;
    waddr     = pos_r[AW-1:0];
    wdata     = ch_r;
    re        = 1'b0;
    raddr     = pos_m1[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (q_valid_i) begin
          if (sess_r) begin
            q_pop_o = 1'b1;
          end else begin
            case (q_item_i.op)
              tlew_pkg::OP_ERASE: begin
                if (pos_r == ZERO) begin
                  q_pop_o = 1'b1;
                end else if (emit_ok) begin
                  q_pop_o        = 1'b1;
                  emit           = 1'b1;
                  emit_tok.kind  = tlew_pkg::KIND_ERASE;
                  emit_tok.count = tlew_pkg::CNT_W'(1);
                  pos_nxt        = pos_m1;
                end
              end
              tlew_pkg::OP_KILL: begin
                if (pos_r == ZERO) begin
                  q_pop_o = 1'b1;
                end else if (emit_ok) begin
                  q_pop_o        = 1'b1;
                  emit           = 1'b1;
                  emit_tok.kind  = tlew_pkg::KIND_ERASE;
                  emit_tok.count = tlew_pkg::CNT_W'(pos_r);
                  pos_nxt        = ZERO;
                end
              end
              tlew_pkg::OP_WORD: begin
                q_pop_o = 1'b1;
                if (pos_r != ZERO) begin
                  scan_nxt  = pos_r;
                  word_nxt  = 1'b0;
                  re        = 1'b1;
                  raddr     = pos_m1[AW-1:0];
                  state_nxt = S_CW;
                end
              end
              tlew_pkg::OP_EOF: begin
                if (pos_r != ZERO) begin
                  q_pop_o = 1'b1;
                end else if (emit_ok) begin
                  q_pop_o       = 1'b1;
                  emit          = 1'b1;
                  emit_tok.kind = tlew_pkg::KIND_END;
                  sess_nxt      = 1'b1;
                end
              end
              tlew_pkg::OP_NEWLINE: begin
                if (emit_ok) begin
                  q_pop_o       = 1'b1;
                  emit          = 1'b1;
                  emit_tok.kind = tlew_pkg::KIND_NEWLINE;
                  pos_nxt       = ZERO;
                end
              end
              tlew_pkg::OP_PRINT: begin
                if (pos_r < LW) begin
                  if (emit_ok) begin
                    q_pop_o       = 1'b1;
                    emit          = 1'b1;
                    emit_tok.echo = q_item_i.ch;
                    we            = 1'b1;
                    wdata         = q_item_i.ch;
                    pos_nxt       = pos_p1;
                  end
                end else begin
                  q_pop_o = 1'b1;
                  ch_nxt  = q_item_i.ch;
                  if (q_item_i.ch == tlew_pkg::CH_SPACE) begin
                    scan_nxt  = ZERO;
                    state_nxt = S_WNL;
                  end else begin
                    scan_nxt  = LW;
                    re        = 1'b1;
                    raddr     = LAST_A;
                    state_nxt = S_WSCAN;
                  end
                end
              end
              tlew_pkg::OP_BELL: begin
                if (emit_ok) begin
                  q_pop_o       = 1'b1;
                  emit          = 1'b1;
                  emit_tok.kind = tlew_pkg::KIND_BELL;
                end
              end
              default: q_pop_o = 1'b1;
            endcase
          end
        end
      end

      // rdata holds line[scan-1]
      S_CW: begin
        if (!rd_space || !word_r) begin
          word_nxt = word_r || !rd_space;
          scan_nxt = scan_m1;
          if (scan_m1 != ZERO) begin
            re    = 1'b1;
            raddr = scan_m2[AW-1:0];
          end else begin
            state_nxt = S_CWEND;
          end
        end else begin
          state_nxt = S_CWEND;
        end
      end

      S_CWEND: begin
        if (scan_r == pos_r) begin
          state_nxt = S_IDLE;
        end else if (emit_ok) begin
          emit           = 1'b1;
          emit_tok.kind  = tlew_pkg::KIND_ERASE;
          emit_tok.count = tlew_pkg::CNT_W'(cw_cnt);
          pos_nxt        = scan_r;
          state_nxt      = S_IDLE;
        end
      end

      // find start of the partial last word
      S_WSCAN: begin
        if (!rd_space) begin
          scan_nxt = scan_m1;
          if (scan_m1 != ZERO) begin
            re    = 1'b1;
            raddr = scan_m2[AW-1:0];
          end else begin
            state_nxt = S_WERASE;
          end
        end else begin
          state_nxt = S_WERASE;
        end
      end

      S_WERASE: begin
        if (scan_r != ZERO && scan_r != LW) begin
          if (emit_ok) begin
            emit           = 1'b1;
            emit_tok.kind  = tlew_pkg::KIND_ERASE;
            emit_tok.count = tlew_pkg::CNT_W'(wrap_cnt);
            emit_tok.last  = 1'b0;
            state_nxt      = S_WNL;
          end
        end else begin
          state_nxt = S_WNL;
        end
      end

      S_WNL: begin
        if (emit_ok) begin
          emit          = 1'b1;
          emit_tok.kind = tlew_pkg::KIND_NEWLINE;
          emit_tok.last = 1'b0;
          pos_nxt       = ZERO;
          if (scan_r != ZERO && scan_r != LW) begin
            re        = 1'b1;
            raddr     = scan_r[AW-1:0];
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_WECHO;
          end
        end
      end

      // rdata holds line[scan]; copy to line[pos] and fetch the next one
      S_MOVE: begin
        if (emit_ok) begin
          emit          = 1'b1;
          emit_tok.echo = rdata;
          emit_tok.last = 1'b0;
          we            = 1'b1;
          wdata         = rdata;
          pos_nxt       = pos_p1;
          scan_nxt      = scan_p1;
          if (scan_p1 != LW) begin
            re    = 1'b1;
            raddr = scan_p1[AW-1:0];
          end else begin
            state_nxt = S_WECHO;
          end
        end
      end

      S_WECHO: begin
        if (emit_ok) begin
          emit          = 1'b1;
          emit_tok.echo = ch_r;
          we            = 1'b1;
          wdata         = ch_r;
          pos_nxt       = pos_p1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tok_nxt = emit ? emit_tok : tok_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (pop_i) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= ZERO;
      sess_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      sess_r  <= sess_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    word_r <= word_nxt;
    ch_r   <= ch_nxt;
    tok_r  <= tok_nxt;
  end

  assign out_valid_o = ov_r;
  assign out_tok_o   = tok_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && ov_r) |-> pop_i)
    else $error("result register overwritten before pop");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LW)
    else $error("cursor beyond line width");

  a_session_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sess_r |=> sess_r)
    else $error("session end flag cleared");

  a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> (pos_r < scan_r))
    else $error("wrap copy destination not below source");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_W = 40;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [tlew_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'd0;

  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_token_kind;
  logic [7:0]  out_echo_value;
  logic [5:0]  out_erase_count;
  logic        out_last_of_run;

  always #1 clk = ~clk;

  terminal_line_editor_word_wrap #(
    .LINE_WIDTH(LINE_W)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .empty          (empty),
    .pop            (pop),
    .out_token_kind (out_token_kind),
    .out_echo_value (out_echo_value),
    .out_erase_count(out_erase_count),
    .out_last_of_run(out_last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Line editor predictor: private copy of the screen line, cursor, session
  // flag and the two key registers.
  // ---------------------------------------------------------------------------
  logic [7:0]  line_buf [LINE_W];
  int          cur_col = 0;
  bit          session_done = 1'b0;
  logic [7:0]  erase_ch = tlew_pkg::ERASE_RST;
  logic [7:0]  kill_ch = tlew_pkg::KILL_RST;

  tlew_pkg::tok_t run_q[$];            // tokens of the keystroke being predicted
  tlew_pkg::tok_t echo_tokens_due[$];  // predicted tokens not yet popped
  logic [7:0]     byte_q[$];           // keystrokes waiting to be pushed

  int          mismatches = 0;
  int          tokens_seen = 0;
  bit          after_print = 1'b0;  // last queued byte was a stored printable

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void note_token(tlew_pkg::kind_t k, logic [7:0] e, logic [5:0] n);
    tlew_pkg::tok_t t;
    t.kind  = k;
    t.echo  = e;
    t.count = n;
    t.last  = 1'b0;
    run_q.push_back(t);
  endfunction

  // One keystroke through the editor; appends its echo run to echo_tokens_due.
  function automatic void edit_line(logic [7:0] c);
    int pos;
    int p;
    int start;
    int i;
    bit got_word;
    logic [7:0] ch;
    tlew_pkg::tok_t t;
    if (session_done) return;
    pos = cur_col;
    run_q.delete();
    // key registers win over the fixed control codes
    if (c == erase_ch) begin
      if (pos > 0) begin
        note_token(tlew_pkg::KIND_ERASE, 8'd0, 6'd1);
        pos--;
      end
    end else if (c == kill_ch) begin
      if (pos > 0) begin
        note_token(tlew_pkg::KIND_ERASE, 8'd0, 6'(pos));
        pos = 0;
      end
    end else if (c == tlew_pkg::CTRL_W) begin
      // skip trailing blanks, then the word before them
      p = pos;
      got_word = 1'b0;
      while (p > 0) begin
        if (line_buf[p-1] != tlew_pkg::CH_SPACE) got_word = 1'b1;
        else if (got_word) break;
        p--;
      end
      if (p < pos) begin
        note_token(tlew_pkg::KIND_ERASE, 8'd0, 6'(pos - p));
        pos = p;
      end
    end else if (c == tlew_pkg::CTRL_D) begin
      if (pos == 0) begin
        note_token(tlew_pkg::KIND_END, 8'd0, 6'd0);
        session_done = 1'b1;
      end
    end else if (c == tlew_pkg::CH_NL) begin
      note_token(tlew_pkg::KIND_NEWLINE, 8'd0, 6'd0);
      pos = 0;
    end else if (c >= tlew_pkg::PRINT_LO && c <= tlew_pkg::PRINT_HI) begin
      if (pos < LINE_W) begin
        line_buf[pos] = c;
        pos++;
        note_token(tlew_pkg::KIND_ECHO, c, 6'd0);
      end else begin
        // full line: find where the last partial word starts
        start = LINE_W;
        if (c != tlew_pkg::CH_SPACE) begin
          while (start > 0 && line_buf[start-1] != tlew_pkg::CH_SPACE) start--;
        end
        pos = 0;
        if (c != tlew_pkg::CH_SPACE && start != 0) begin
          if (start < LINE_W) begin
            note_token(tlew_pkg::KIND_ERASE, 8'd0, 6'(LINE_W - start));
          end
          note_token(tlew_pkg::KIND_NEWLINE, 8'd0, 6'd0);
          for (i = start; i < LINE_W; i++) begin
            ch = line_buf[i];
            line_buf[pos] = ch;
            pos++;
            note_token(tlew_pkg::KIND_ECHO, ch, 6'd0);
          end
        end else begin
          note_token(tlew_pkg::KIND_NEWLINE, 8'd0, 6'd0);
        end
        if (pos < LINE_W) begin
          line_buf[pos] = c;
          pos++;
        end
        note_token(tlew_pkg::KIND_ECHO, c, 6'd0);
      end
    end else begin
      note_token(tlew_pkg::KIND_BELL, 8'd0, 6'd0);
    end
    cur_col = pos;
    foreach (run_q[k]) begin
      t = run_q[k];
      t.last = (k == run_q.size() - 1);
      echo_tokens_due.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Keystroke generation. Ctrl-D is only queued right after a stored
  // printable, so the session cannot end before the closing phase.
  // ---------------------------------------------------------------------------
  function automatic void send_byte(logic [7:0] b);
    byte_q.push_back(b);
    after_print = (b >= tlew_pkg::PRINT_LO && b <= tlew_pkg::PRINT_HI &&
                   b != erase_ch && b != kill_ch);
  endfunction

  function automatic logic [7:0] pick_printable(bit with_space);
    logic [7:0] b;
    do begin
      if (with_space && $urandom_range(0, 6) == 0) b = tlew_pkg::CH_SPACE;
      else b = 8'($urandom_range(33, 127));
    end while (b == erase_ch || b == kill_ch);
    return b;
  endfunction

  // control bytes and high bytes that only ring the bell
  function automatic logic [7:0] pick_bell();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 1) == 1) b = 8'($urandom_range(128, 255));
      else b = 8'($urandom_range(0, 31));
    end while (b == tlew_pkg::CTRL_D || b == tlew_pkg::CTRL_W || b == tlew_pkg::CH_NL ||
               b == erase_ch || b == kill_ch);
    return b;
  endfunction

  // Typing with random content; mostly text so lines fill up and wrap.
  task automatic queue_mixed(int n);
    int r;
    logic [7:0] b;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 78) b = pick_printable(1'b0);
      else if (r < 92) b = tlew_pkg::CH_SPACE;
      else if (r < 94) b = erase_ch;
      else if (r < 95) b = kill_ch;
      else if (r < 97) b = tlew_pkg::CTRL_W;
      else if (r < 98) b = tlew_pkg::CH_NL;
      else if (r < 99 || !after_print) b = pick_bell();
      else b = tlew_pkg::CTRL_D;
      send_byte(b);
    end
  endtask

  // Fresh line filled to the margin, then one more byte to force a wrap.
  // style 0: no blank at all, 1: blank only in column 0, 2: ends in a blank.
  task automatic queue_full_line(int style, bit space_trigger);
    int i;
    send_byte(tlew_pkg::CH_NL);
    for (i = 0; i < LINE_W; i++) begin
      if ((style == 1 && i == 0) || (style == 2 && i == LINE_W - 1)) begin
        send_byte(tlew_pkg::CH_SPACE);
      end else begin
        send_byte(pick_printable(style == 2));
      end
    end
    send_byte(space_trigger ? tlew_pkg::CH_SPACE : pick_printable(1'b0));
  endtask

  // ---------------------------------------------------------------------------
  // Config port access, APB style: setup cycle then access cycle.
  // ---------------------------------------------------------------------------
  task automatic cfg_access(logic idx, bit wr, logic [7:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, wdata};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Block must be drained: no queued bytes, no tokens due, plus the longest
  // wrap walk for keystrokes that produce nothing.
  task automatic wait_idle();
    while (byte_q.size() != 0 || echo_tokens_due.size() != 0) @(posedge clk);
    repeat (4 * LINE_W) @(posedge clk);
  endtask

  task automatic set_keys(logic [7:0] e, logic [7:0] k);
    logic [31:0] rd;
    wait_idle();
    cfg_access(tlew_pkg::REG_ERASE, 1'b1, e, rd);
    cfg_access(tlew_pkg::REG_KILL, 1'b1, k, rd);
    erase_ch    = e;
    kill_ch     = k;
    after_print = 1'b0;
    cfg_access(tlew_pkg::REG_ERASE, 1'b0, 8'd0, rd);
    if (rd[7:0] != e) flag_mismatch($sformatf("erase key readback %0d, wrote %0d", rd[7:0], e));
    cfg_access(tlew_pkg::REG_KILL, 1'b0, 8'd0, rd);
    if (rd[7:0] != k) flag_mismatch($sformatf("kill key readback %0d, wrote %0d", rd[7:0], k));
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: bursts of pushes with random gaps, changes on falling edge.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left--;
      push    <= 1'b0;
      in_byte <= 8'($urandom_range(0, 255));
    end else if (byte_q.size() != 0) begin
      push    <= 1'b1;
      in_byte <= byte_q[0];
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        // one in three bursts runs straight into the next one
        burst_left = $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      push <= 1'b0;
    end
  end

  // Input monitor: each accepted keystroke goes through the predictor.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      edit_line(in_byte);
      void'(byte_q.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: pop follows its own run/stall pattern.
  // ---------------------------------------------------------------------------
  int pop_left = 0;
  bit stall_now;

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_left != 0) begin
      pop_left--;
    end else begin
      stall_now = ($urandom_range(0, 2) == 0);
      pop_left  = stall_now ? $urandom_range(1, 20) : $urandom_range(1, 40);
      pop <= !stall_now;
    end
  end

  // Output monitor: every popped token against the oldest prediction.
  always @(posedge clk) begin : watch_tokens
    tlew_pkg::tok_t want;
    if (rst_n && pop && !empty) begin
      tokens_seen++;
      if (echo_tokens_due.size() == 0) begin
        flag_mismatch($sformatf("token %0d popped with none predicted: kind %0d echo %0d",
                                tokens_seen, out_token_kind, out_echo_value));
      end else begin
        want = echo_tokens_due.pop_front();
        if (want.kind != out_token_kind || want.echo != out_echo_value ||
            want.count != out_erase_count || want.last != out_last_of_run) begin
          flag_mismatch($sformatf(
            "token %0d want kind %0d echo %0d count %0d last %0d, got %0d %0d %0d %0d",
            tokens_seen, want.kind, want.echo, want.count, want.last,
            out_token_kind, out_echo_value, out_erase_count, out_last_of_run));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Opening keystrokes under reset keys: nothing to erase at column zero,
  // bells at both byte extremes, Ctrl-D mid-line, word erase over a word,
  // over blanks only, and over blanks then a word; erase, kill, newline.
  // ---------------------------------------------------------------------------
  logic [7:0] opening [26] = '{
    tlew_pkg::ERASE_RST, tlew_pkg::KILL_RST, tlew_pkg::CTRL_W, 8'h00, 8'hFF, 8'd31,
    tlew_pkg::CH_SPACE, "A", "~", tlew_pkg::CTRL_D, tlew_pkg::CTRL_W,
    tlew_pkg::CH_SPACE, tlew_pkg::CTRL_W,
    "z", tlew_pkg::ERASE_RST, "q", "r", tlew_pkg::KILL_RST,
    "a", "b", tlew_pkg::CH_SPACE, tlew_pkg::CH_SPACE, tlew_pkg::CTRL_W,
    tlew_pkg::CH_NL, "m", tlew_pkg::CH_NL
  };

  initial begin : sequencer
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset keys: opening list, wrap with no break point, widest wrap
    foreach (opening[i]) send_byte(opening[i]);
    queue_full_line(0, 1'b0);
    queue_mixed(6);
    queue_full_line(1, 1'b0);

    // extreme key codes; wrap of a line that ends in a blank
    set_keys(8'd0, 8'd255);
    queue_mixed(6);
    send_byte(8'h00);
    send_byte(8'hFF);
    queue_full_line(2, 1'b0);

    // keys shadowing newline and Ctrl-W; code 127 becomes a stored character
    set_keys(tlew_pkg::CH_NL, tlew_pkg::CTRL_W);
    queue_mixed(5);
    send_byte(tlew_pkg::PRINT_HI);
    send_byte(tlew_pkg::CH_NL);
    send_byte(tlew_pkg::CTRL_W);
    queue_mixed(5);

    // printable erase key, Ctrl-D used as kill; blank arriving at the margin
    set_keys("a", tlew_pkg::CTRL_D);
    queue_full_line(0, 1'b1);
    queue_mixed(6);

    // back to reset keys, then end the session; the rest must be dropped
    set_keys(tlew_pkg::ERASE_RST, tlew_pkg::KILL_RST);
    queue_mixed(6);
    send_byte(tlew_pkg::CH_NL);
    send_byte(tlew_pkg::CTRL_D);
    send_byte("a");
    send_byte(tlew_pkg::CTRL_D);
    send_byte(tlew_pkg::ERASE_RST);
    send_byte(tlew_pkg::CH_NL);

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far past the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
